/* rtl/core/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SFD_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);
`define SFD_ASSERT_RST(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define SFD_ASSERT(lbl, clk_s, rstn_s, prop, msg)
`define SFD_ASSERT_RST(lbl, clk_s, prop, msg)
`endif
`endif

/* rtl/core/sfd_pkg.sv */
// Shared types, constants and CRC function of the sync frame deframer.
package sfd_pkg;

  localparam int unsigned FRAME_MIN = 6;
  localparam logic [7:0]  CRC_INIT  = 8'h00;
  localparam logic [7:0]  CRC_POLY  = 8'h07;

  localparam logic CFG_SYNC_FIRST  = 1'b0;
  localparam logic CFG_SYNC_SECOND = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_HDR,
    ST_EMIT
  } parse_state_t;

  typedef struct packed {
    logic [7:0] frame_type;
    logic [7:0] sequence_res;
    logic [5:0] payload_length;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic       empty_frame;
    logic       last;
  } result_t;

  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ CRC_POLY;
      else      c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* rtl/core/sfd_parser.sv */
// Front part: byte buffer memory and frame parser that classifies held bytes.
module sfd_parser #(
  parameter int unsigned BUFFER_BYTES = 64,
  parameter int unsigned PAYLOAD_MAX  = 58
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  input  logic [7:0]                          byte_in,
  input  logic [7:0]                          sync_first,
  input  logic [7:0]                          sync_second,
  input  logic                                q_full,
  output logic                                q_push,
  output sfd_pkg::result_t                    q_word,
  output logic                                busy,
  output logic [$clog2(BUFFER_BYTES+1)-1:0]   held
);

  localparam int unsigned AW = $clog2(BUFFER_BYTES);
  localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);
  localparam logic [CW:0] NBIG  = (CW+1)'(BUFFER_BYTES);
  localparam logic [9:0]  PMAX  = 10'(PAYLOAD_MAX);
  localparam logic [9:0]  FMIN  = 10'(sfd_pkg::FRAME_MIN);

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] a, input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= NBIG) s = s - NBIG;
    return s[AW-1:0];
  endfunction

  logic [7:0] mem [BUFFER_BYTES];

  sfd_pkg::parse_state_t state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [7:0]    prev_r, prev_nxt;
  logic [7:0]    crc_r, crc_nxt;
  logic [7:0]    type_r, type_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    seq_r, seq_nxt;
  logic [7:0]    rd_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          wr_en;
  logic [9:0]    cnt10;
  logic [9:0]    k10;
  logic [9:0]    len10;
  logic [9:0]    pos10;
  logic [9:0]    size10;
  logic [7:0]    crc_upd;
  logic [5:0]    idx6;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfd_pkg::ST_IDLE;
      head_r  <= '0;
      count_r <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    crc_r  <= crc_nxt;
    type_r <= type_nxt;
    len_r  <= len_nxt;
    seq_r  <= seq_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= byte_in;
    rd_q <= mem[rd_addr];
  end

  assign rd_addr = wrap(head_nxt, k_nxt);
  assign cnt10   = 10'(count_r);
  assign k10     = 10'(k_r);
  assign len10   = 10'(len_r);
  assign size10  = FMIN + len10;
  assign pos10   = k10 - 10'd1;
  assign crc_upd = sfd_pkg::crc_byte((k_r == CW'(2)) ? sfd_pkg::CRC_INIT : crc_r, rd_q);
  assign idx6    = 6'(k10 - 10'd5);
  assign busy    = (state_r != sfd_pkg::ST_IDLE);
  assign held    = count_r;

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    count_nxt = count_r;
    k_nxt     = k_r;
    prev_nxt  = prev_r;
    crc_nxt   = crc_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    seq_nxt   = seq_r;
    wr_en     = 1'b0;
    wr_addr   = head_r;
    q_push    = 1'b0;
    q_word    = '{frame_type: type_r, sequence_res: seq_r, payload_length: 6'(len_r),
                  payload_byte: rd_q, byte_index: idx6, empty_frame: 1'b0,
                  last: (k10 - 10'd4 == len10)};
    unique case (state_r)
      sfd_pkg::ST_IDLE: begin
        if (push) begin
          wr_en = 1'b1;
          if (cnt10 == 10'(BUFFER_BYTES)) begin
            wr_addr   = head_r;
            count_nxt = CW'(1);
          end else begin
            wr_addr   = wrap(head_r, count_r);
            count_nxt = count_r + CW'(1);
            if (cnt10 + 10'd1 >= FMIN) begin
              state_nxt = sfd_pkg::ST_SEARCH;
              k_nxt     = '0;
            end
          end
        end
      end
      sfd_pkg::ST_SEARCH: begin
        if (k_r != '0 && prev_r == sync_first && rd_q == sync_second) begin
          head_nxt  = wrap(head_r, CW'(pos10));
          count_nxt = CW'(cnt10 - pos10);
          if (cnt10 - pos10 < FMIN) begin
            state_nxt = sfd_pkg::ST_IDLE;
          end else begin
            state_nxt = sfd_pkg::ST_HDR;
            k_nxt     = CW'(2);
          end
        end else if (k10 + 10'd1 == cnt10) begin
          count_nxt = '0;
          state_nxt = sfd_pkg::ST_IDLE;
        end else begin
          k_nxt    = k_r + CW'(1);
          prev_nxt = rd_q;
        end
      end
      sfd_pkg::ST_HDR: begin
        if (k10 >= 10'd5 && k10 == len10 + 10'd5) begin
          if (rd_q == crc_r) begin
            state_nxt = sfd_pkg::ST_EMIT;
            k_nxt     = CW'(5);
          end else begin
            head_nxt  = wrap(head_r, CW'(2));
            count_nxt = count_r - CW'(2);
            k_nxt     = '0;
            state_nxt = (cnt10 - 10'd2 >= FMIN) ? sfd_pkg::ST_SEARCH : sfd_pkg::ST_IDLE;
          end
        end else begin
          crc_nxt = crc_upd;
          k_nxt   = k_r + CW'(1);
          if (k_r == CW'(2)) type_nxt = rd_q;
          if (k_r == CW'(4)) seq_nxt = rd_q;
          if (k_r == CW'(3)) begin
            len_nxt = rd_q;
            if (10'(rd_q) > PMAX) begin
              head_nxt  = wrap(head_r, CW'(2));
              count_nxt = count_r - CW'(2);
              k_nxt     = '0;
              state_nxt = (cnt10 - 10'd2 >= FMIN) ? sfd_pkg::ST_SEARCH : sfd_pkg::ST_IDLE;
            end else if (cnt10 < FMIN + 10'(rd_q)) begin
              state_nxt = sfd_pkg::ST_IDLE;
            end
          end
        end
      end
      sfd_pkg::ST_EMIT: begin
        if (len_r == 8'd0) begin
          q_word.payload_byte = '0;
          q_word.byte_index   = '0;
          q_word.empty_frame  = 1'b1;
          q_word.last         = 1'b1;
        end
        if (!q_full) begin
          q_push = 1'b1;
          if (q_word.last) begin
            head_nxt  = wrap(head_r, CW'(size10));
            count_nxt = CW'(cnt10 - size10);
            k_nxt     = '0;
            state_nxt = (cnt10 - size10 >= FMIN) ? sfd_pkg::ST_SEARCH : sfd_pkg::ST_IDLE;
          end else begin
            k_nxt = k_r + CW'(1);
          end
        end
      end
      default: state_nxt = sfd_pkg::ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/sfd_fifo.sv */
// Back part: result word queue between the parser and the output ports.
module sfd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  sfd_pkg::result_t wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output sfd_pkg::result_t rdata
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  sfd_pkg::result_t store_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = store_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    if (do_pop)  rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    if (do_push && !do_pop) cnt_nxt = cnt_r + CW'(1);
    if (!do_push && do_pop) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) store_r[wp_r] <= wdata;
  end

endmodule

/* rtl/core/sync_frame_deframer_crc8.sv */
// Sync frame deframer top level: config registers, parser and result queue.
// An accepted byte is written into the buffer memory; parsing then walks the memory
// one byte per cycle: over the held bytes for the sync search, over the type, length,
// sequence and payload bytes for the CRC check, and over the result words, which wait
// while the result queue is full; in_full stays high until parsing is done.
// Bytes are taken one per cycle while fewer than six are held; once six or more are
// held, each byte starts a walk that must end before another byte is taken. Each
// rejected sync pair drops two bytes and the walk rescans. Reset: synchronous, active low.
`include "assert_macros.svh"
module sync_frame_deframer_crc8 #(
  parameter int unsigned BUFFER_BYTES = 64,
  parameter int unsigned PAYLOAD_MAX  = 58
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_rx_byte,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_frame_type,
  output logic [7:0] out_sequence_res,
  output logic [5:0] out_payload_length,
  output logic [7:0] out_payload_byte,
  output logic [5:0] out_byte_index,
  output logic       out_empty_frame,
  output logic       out_last,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata
);

  localparam int unsigned CW = $clog2(BUFFER_BYTES + 1);

  logic [7:0]       sync_first_r;
  logic [7:0]       sync_second_r;
  logic             busy;
  logic [CW-1:0]    held;
  logic             q_full;
  logic             q_push;
  sfd_pkg::result_t q_word;
  sfd_pkg::result_t q_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_first_r  <= 8'hAA;
      sync_second_r <= 8'h55;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sfd_pkg::CFG_SYNC_FIRST:  sync_first_r  <= cfg_wdata;
        sfd_pkg::CFG_SYNC_SECOND: sync_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_full = busy;

  sfd_parser #(
    .BUFFER_BYTES(BUFFER_BYTES),
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push && !busy),
    .byte_in    (in_rx_byte),
    .sync_first (sync_first_r),
    .sync_second(sync_second_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_word     (q_word),
    .busy       (busy),
    .held       (held)
  );

  sfd_fifo #(
    .DEPTH(4)
  ) u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_word),
    .full (q_full),
    .pop  (out_pop),
    .empty(out_empty),
    .rdata(q_out)
  );

  assign out_frame_type     = q_out.frame_type;
  assign out_sequence_res   = q_out.sequence_res;
  assign out_payload_length = q_out.payload_length;
  assign out_payload_byte   = q_out.payload_byte;
  assign out_byte_index     = q_out.byte_index;
  assign out_empty_frame    = q_out.empty_frame;
  assign out_last           = q_out.last;

  `SFD_ASSERT(a_held_bound, clk, rst_n, (held <= CW'(BUFFER_BYTES)), "held count above buffer size")
  `SFD_ASSERT(a_byte_stored, clk, rst_n, (in_push && !in_full) |=> (held == $past(held) + CW'(1) || held == CW'(1)), "accepted byte not stored")
  `SFD_ASSERT(a_result_holds, clk, rst_n, (!out_empty && !out_pop) |=> (!out_empty && $stable(q_out)), "waiting result word lost")
  `SFD_ASSERT(a_empty_last, clk, rst_n, (!out_empty && out_empty_frame) |-> out_last, "empty frame word not marked last")

endmodule

/* verif/sync_frame_deframer_crc8_tb.sv */
// Testbench for the sync frame deframer: predicts frames from received bytes and checks words.
module sync_frame_deframer_crc8_tb;

  localparam int STORE_BYTES = 64;
  localparam int LEN_MAX     = 58;
  localparam int SETTLE      = 400;
  localparam int WDOG_LIMIT  = 20000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [7:0] out_frame_type;
  logic [7:0] out_sequence_res;
  logic [5:0] out_payload_length;
  logic [7:0] out_payload_byte;
  logic [5:0] out_byte_index;
  logic       out_empty_frame;
  logic       out_last;
  logic       cfg_we = 1'b0;
  logic       cfg_index = sfd_pkg::CFG_SYNC_FIRST;
  logic [7:0] cfg_wdata = 8'h00;

  sync_frame_deframer_crc8 i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [7:0]       rx_q[$];
  sfd_pkg::result_t frame_words_q[$];
  logic [7:0]       rx_store[STORE_BYTES];
  int               rx_held;
  logic [7:0]       sync_a = 8'hAA;
  logic [7:0]       sync_b = 8'h55;
  int               errors, n_bytes, n_words, n_frames;
  bit               quiet, hold_req, hold_done;
  int               gap_left, stall_left, hold_left, idle_cycles;

  function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] d);
    logic [7:0] r;
    r = c ^ d;
    for (int k = 0; k < 8; k++) r = r[7] ? ((r << 1) ^ 8'h07) : (r << 1);
    return r;
  endfunction

  task automatic drop_bytes(input int n);
    if (n >= rx_held) begin
      rx_held = 0;
    end else begin
      for (int i = 0; i < rx_held - n; i++) rx_store[i] = rx_store[i + n];
      rx_held -= n;
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    int pos, len;
    bit found;
    logic [7:0] c;
    sfd_pkg::result_t r;
    if (rx_held >= STORE_BYTES) rx_held = 0;
    rx_store[rx_held] = b;
    rx_held++;
    while (rx_held >= 6) begin
      found = 0;
      for (pos = 0; pos + 1 < rx_held; pos++)
        if (rx_store[pos] == sync_a && rx_store[pos + 1] == sync_b) begin
          found = 1;
          break;
        end
      if (!found) begin
        rx_held = 0;
        break;
      end
      if (pos > 0) drop_bytes(pos);
      if (rx_held < 6) break;
      len = rx_store[3];
      if (len > LEN_MAX) begin
        drop_bytes(2);
        continue;
      end
      if (rx_held < 6 + len) break;
      c = 8'h00;
      for (int i = 2; i < 5 + len; i++) c = crc8_step(c, rx_store[i]);
      if (c != rx_store[5 + len]) begin
        drop_bytes(2);
        continue;
      end
      r.frame_type     = rx_store[2];
      r.sequence_res   = rx_store[4];
      r.payload_length = len[5:0];
      if (len == 0) begin
        r.payload_byte = 8'h00;
        r.byte_index   = 6'd0;
        r.empty_frame  = 1'b1;
        r.last         = 1'b1;
        frame_words_q.push_back(r);
      end else begin
        for (int i = 0; i < len; i++) begin
          r.payload_byte = rx_store[5 + i];
          r.byte_index   = i[5:0];
          r.empty_frame  = 1'b0;
          r.last         = (i + 1 == len);
          frame_words_q.push_back(r);
        end
      end
      n_frames++;
      drop_bytes(6 + len);
    end
  endtask

  // Driver: send queued bytes, idle in bursts.
  always @(posedge clk) begin
    logic nxt_push;
    logic [7:0] nxt_byte;
    nxt_push = 1'b0;
    nxt_byte = in_rx_byte;
    if (rst_n) begin
      if (in_push && !in_full) begin
        deframe_byte(in_rx_byte);
        void'(rx_q.pop_front());
        n_bytes++;
      end
      if (gap_left > 0) begin
        gap_left--;
      end else if (rx_q.size() > 0) begin
        if (!quiet && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 4);
        end else begin
          nxt_push = 1'b1;
          nxt_byte = rx_q[0];
        end
      end
    end
    in_push    <= nxt_push;
    in_rx_byte <= nxt_byte;
  end

  // Receiver: stall in bursts, hold off once for a long stretch.
  always @(posedge clk) begin
    logic nxt_pop;
    nxt_pop = 1'b0;
    if (rst_n) begin
      if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = 800;
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
      end else begin
        nxt_pop = 1'b1;
      end
    end
    out_pop <= nxt_pop;
  end

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Monitor: compare each popped word with the oldest prediction.
  always @(posedge clk) begin
    sfd_pkg::result_t e;
    if (rst_n && out_pop && !out_empty) begin
      n_words++;
      if (frame_words_q.size() == 0) begin
        $error("unexpected word: type %0d index %0d", out_frame_type, out_byte_index);
        errors++;
      end else begin
        e = frame_words_q.pop_front();
        check_field("frame_type", e.frame_type, out_frame_type);
        check_field("sequence_res", e.sequence_res, out_sequence_res);
        check_field("payload_length", e.payload_length, out_payload_length);
        check_field("payload_byte", e.payload_byte, out_payload_byte);
        check_field("byte_index", e.byte_index, out_byte_index);
        check_field("empty_frame", e.empty_frame, out_empty_frame);
        check_field("last", e.last, out_last);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WDOG_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", WDOG_LIMIT);
      $display("sync_frame_deframer_crc8_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_frame(input logic [7:0] ftype, input int len, input logic [7:0] seq,
                             input bit bad_crc);
    logic [7:0] c;
    logic [7:0] d;
    c = 8'h00;
    rx_q.push_back(sync_a);
    rx_q.push_back(sync_b);
    rx_q.push_back(ftype);
    rx_q.push_back(len[7:0]);
    rx_q.push_back(seq);
    c = crc8_step(crc8_step(crc8_step(c, ftype), len[7:0]), seq);
    for (int i = 0; i < len; i++) begin
      d = 8'($urandom_range(0, 255));
      rx_q.push_back(d);
      c = crc8_step(c, d);
    end
    rx_q.push_back(bad_crc ? c ^ (8'h01 << $urandom_range(0, 7)) : c);
  endtask

  task automatic write_sync(input logic idx, input logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    if (idx == sfd_pkg::CFG_SYNC_FIRST) sync_a = v;
    else sync_b = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (rx_q.size() > 0 || in_push || in_full || frame_words_q.size() > 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic queue_random(input int n_frames_req);
    int k;
    for (int f = 0; f < n_frames_req; f++) begin
      k = $urandom_range(0, 9);
      if (k < 7) begin
        queue_frame(8'($urandom_range(0, 255)), int'($urandom_range(0, 6)),
                    8'($urandom_range(0, 255)), 1'b0);
      end else if (k == 7) begin
        queue_frame(8'($urandom_range(0, 255)), int'($urandom_range(0, 6)),
                    8'($urandom_range(0, 255)), 1'b1);
      end else begin
        repeat ($urandom_range(1, 4)) rx_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    logic [7:0] c;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_frame(8'h11, 1, 8'h22, 1'b1);
    // length above limit, then an empty frame behind it
    rx_q.push_back(sync_a); rx_q.push_back(sync_b); rx_q.push_back(8'h01);
    rx_q.push_back(8'd59); rx_q.push_back(8'h02);
    queue_frame(8'h33, 0, 8'h44, 1'b0);
    // no sync pair, trailing first sync byte
    repeat (5) rx_q.push_back(8'h13);
    rx_q.push_back(sync_a);
    // bad outer frame hiding two good ones: both come out in one step
    rx_q.push_back(sync_a); rx_q.push_back(sync_b); rx_q.push_back(8'h77);
    rx_q.push_back(8'd13); rx_q.push_back(8'h01);
    queue_frame(8'h21, 0, 8'h09, 1'b0);
    queue_frame(8'h22, 1, 8'h0A, 1'b0);
    c = 8'h00;
    for (int i = rx_q.size() - 16; i < rx_q.size(); i++) c = crc8_step(c, rx_q[i]);
    rx_q.push_back(~c);
    drain();

    // long receiver hold while a maximum-length frame arrives
    write_sync(sfd_pkg::CFG_SYNC_FIRST, 8'($urandom_range(0, 255)));
    write_sync(sfd_pkg::CFG_SYNC_SECOND, 8'($urandom_range(0, 255)));
    hold_req = 1;
    queue_frame(8'($urandom_range(0, 255)), LEN_MAX, 8'($urandom_range(0, 255)), 1'b0);
    queue_frame(8'($urandom_range(0, 255)), 0, 8'($urandom_range(0, 255)), 1'b0);
    drain();

    write_sync(sfd_pkg::CFG_SYNC_FIRST, 8'h00);
    write_sync(sfd_pkg::CFG_SYNC_SECOND, 8'hFF);
    queue_frame(8'hFF, 2, 8'h00, 1'b0);
    queue_random(1);
    drain();

    write_sync(sfd_pkg::CFG_SYNC_FIRST, 8'hFF);
    write_sync(sfd_pkg::CFG_SYNC_SECOND, 8'h00);
    quiet = 1;
    queue_frame(8'h00, 1, 8'hFF, 1'b0);
    drain();

    $display("sent %0d bytes, checked %0d words from %0d frames", n_bytes, n_words, n_frames);
    $display("covered bad length, bad CRC, no sync, nested frames, empty and maximum frames");
    if (errors == 0 && frame_words_q.size() == 0) begin
      $display("sync_frame_deframer_crc8_tb OK");
    end else begin
      $display("sync_frame_deframer_crc8_tb NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/sfd_pkg.sv
rtl/core/sfd_parser.sv
rtl/core/sfd_fifo.sv
rtl/core/sync_frame_deframer_crc8.sv
verif/sync_frame_deframer_crc8_tb.sv
